FILE: hdl/bat_pkg.sv
package bat_pkg;

   // Field widths of the two channels
   localparam int OP_W     = 2;
   localparam int UNITS_W  = 9;
   localparam int OFFSET_W = 8;
   localparam int WANT_W   = UNITS_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_NOT_ALLOC = 2'd2
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [UNITS_W-1:0]  request_units;
      logic [OFFSET_W-1:0] block_offset;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [OFFSET_W-1:0] granted_offset;
      logic [UNITS_W-1:0]  block_units;
   } rsp_type;

   // Controller to datapath: one action per cycle (found may ride with restore)
   typedef struct packed {
      logic       init;       // clearing pass: write one node
      logic       load;       // capture request, read root or leaf
      logic       probe;      // read left child of current node
      logic       desc;       // step down one level, mark node at target level
      logic       mark_root;  // whole pool granted
      logic       climb;      // step up one level while looking for used node
      logic       found;      // latch block size of used node
      logic       restore;    // free: write size back into used node
      logic       up;         // recompute parent from node and its buddy
      logic       finish;     // load result register
      status_type status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic init_last;
      logic off_bad;
      logic fits;
      logic want_root;
      logic desc_last;
      logic rd_zero;
      logic idx_zero;
      logic up_last;
      logic rsp_free;
   } sts_type;

   // Smallest power of two not below n; zero counts as one
   function automatic logic [WANT_W-1:0] round_pow2(input logic [UNITS_W-1:0] n);
      logic [UNITS_W-1:0] m;
      logic [WANT_W-1:0]  p;
      m = n - UNITS_W'(1);
      p = WANT_W'(1);
      for (int i = 0; i < UNITS_W; i++) begin
         if (m[i]) begin
            p = WANT_W'(1) << (i + 1);
         end
      end
      if (n == '0) begin
         p = WANT_W'(1);
      end
      return p;
   endfunction

endpackage

FILE: hdl/bat_ram.sv
module bat_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 511
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/bat_dp.sv
module bat_dp
   import bat_pkg::*;
#(
   parameter int POOL_UNITS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int LEVELS = $clog2(POOL_UNITS);
   localparam int VW     = LEVELS + 1;          // node value width
   localparam int NW     = LEVELS + 1;          // node index width
   localparam int NODES  = 2 * POOL_UNITS - 1;
   localparam int CW     = (VW > WANT_W) ? VW : WANT_W;

   logic [NW-1:0]     idx_ff, idx_in;
   logic [VW-1:0]     sz_ff, sz_in;
   logic [VW-1:0]     cur_ff, cur_in;
   logic [VW-1:0]     want_ff, want_in;
   logic              too_big_ff, too_big_in;
   logic              free_ff, free_in;
   logic [LEVELS-1:0] goff_ff, goff_in;
   logic [VW-1:0]     units_ff, units_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [NW-1:0]     wr_addr, rd_addr;
   logic [VW-1:0]     wr_data, rd_data;

   logic [WANT_W-1:0] want_req;
   logic [CW-1:0]     off_ext, units_ext, goff_ext;
   logic [NW-1:0]     leaf, lchild, rchild, parent, sibling, psibling, nidx, nxt;
   logic [VW-1:0]     nsz, psz, merged;
   logic [VW:0]       pair_sum;
   logic              go_left;

   bat_ram #(
      .WIDTH (VW),
      .DEPTH (NODES)
   ) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Tree navigation
   assign want_req = round_pow2(req_data.request_units);
   assign off_ext  = CW'(req_data.block_offset);
   assign leaf     = NW'(off_ext[LEVELS-1:0]) + NW'(POOL_UNITS - 1);
   assign lchild   = (idx_ff << 1) + NW'(1);
   assign rchild   = (idx_ff << 1) + NW'(2);
   assign parent   = (idx_ff - NW'(1)) >> 1;
   assign sibling  = idx_ff[0] ? idx_ff + NW'(1) : idx_ff - NW'(1);
   assign psibling = parent[0] ? parent + NW'(1) : parent - NW'(1);
   assign nxt      = idx_ff + NW'(1);
   assign go_left  = rd_data >= want_ff;
   assign nidx     = go_left ? lchild : rchild;
   assign nsz      = sz_ff >> 1;
   assign psz      = sz_ff << 1;

   // Parent value: buddies merge on free when both halves are whole
   assign pair_sum = {1'b0, cur_ff} + {1'b0, rd_data};
   always_comb begin
      merged = (cur_ff > rd_data) ? cur_ff : rd_data;
      if (free_ff && pair_sum == {1'b0, psz}) begin
         merged = psz;
      end
   end

   // Status toward controller
   always_comb begin
      sts.init_last = idx_ff == NW'(NODES - 1);
      sts.off_bad   = off_ext >= CW'(POOL_UNITS);
      sts.fits      = !too_big_ff && go_left;
      sts.want_root = want_ff == VW'(POOL_UNITS);
      sts.desc_last = nsz == want_ff;
      sts.rd_zero   = rd_data == '0;
      sts.idx_zero  = idx_ff == '0;
      sts.up_last   = parent == '0;
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // Memory port selection
   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = sz_ff;
      if (cmd.load) begin
         rd_addr = (req_data.op == OP_ALLOC) ? '0 : leaf;
      end
      if (cmd.probe) begin
         rd_addr = lchild;
      end
      if (cmd.desc) begin
         if (sts.desc_last) begin
            wr_en   = 1'b1;
            wr_addr = nidx;
            wr_data = '0;
            rd_addr = nidx[0] ? nidx + NW'(1) : nidx - NW'(1);
         end else begin
            rd_addr = go_left ? (lchild << 1) + NW'(1) : (rchild << 1) + NW'(1);
         end
      end
      if (cmd.mark_root) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = '0;
      end
      if (cmd.climb) begin
         rd_addr = parent;
      end
      if (cmd.restore) begin
         wr_en   = 1'b1;
         rd_addr = sibling;
      end
      if (cmd.up) begin
         wr_en   = 1'b1;
         wr_addr = parent;
         wr_data = merged;
         rd_addr = psibling;
      end
      if (cmd.init) begin
         wr_en = 1'b1;
      end
   end

   // Register next values
   always_comb begin
      idx_in       = idx_ff;
      sz_in        = sz_ff;
      cur_in       = cur_ff;
      want_in      = want_ff;
      too_big_in   = too_big_ff;
      free_in      = free_ff;
      goff_in      = goff_ff;
      units_in     = units_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      units_ext    = CW'(units_ff);
      goff_ext     = CW'(goff_ff);
      if (cmd.init) begin
         idx_in = nxt;
         if (((nxt + NW'(1)) & nxt) == '0) begin
            sz_in = nsz;
         end
      end
      if (cmd.load) begin
         want_in    = VW'(want_req);
         too_big_in = CW'(want_req) > CW'(POOL_UNITS);
         free_in    = req_data.op == OP_FREE;
         goff_in    = '0;
         if (req_data.op == OP_ALLOC) begin
            idx_in   = '0;
            sz_in    = VW'(POOL_UNITS);
            units_in = VW'(want_req);
         end else begin
            idx_in   = leaf;
            sz_in    = VW'(1);
            units_in = '0;
         end
      end
      if (cmd.desc) begin
         idx_in = nidx;
         sz_in  = nsz;
         cur_in = '0;
         if (!go_left) begin
            goff_in = goff_ff + nsz[LEVELS-1:0];
         end
      end
      if (cmd.climb) begin
         idx_in = parent;
         sz_in  = psz;
      end
      if (cmd.found) begin
         units_in = sz_ff;
      end
      if (cmd.restore) begin
         cur_in = sz_ff;
      end
      if (cmd.up) begin
         idx_in = parent;
         sz_in  = psz;
         cur_in = merged;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_in.status = cmd.status;
         if (cmd.status == ST_OK) begin
            rsp_in.granted_offset = goff_ext[OFFSET_W-1:0];
            rsp_in.block_units    = units_ext[UNITS_W-1:0];
         end else begin
            rsp_in.granted_offset = '0;
            rsp_in.block_units    = '0;
         end
      end
   end

   // Control registers and clearing-pass cursor
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         sz_ff        <= VW'(POOL_UNITS);
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         sz_ff        <= sz_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      want_ff    <= want_in;
      too_big_ff <= too_big_in;
      free_ff    <= free_in;
      goff_ff    <= goff_in;
      units_ff   <= units_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/bat_ctrl.sv
module bat_ctrl
   import bat_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_ready,
   input  sts_type         sts,
   output cmd_type         cmd
);

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_CHECK = 7'b0000100,
      S_DESC  = 7'b0001000,
      S_CLIMB = 7'b0010000,
      S_UP    = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   status_type      res_ff, res_in;
   logic [OP_W-1:0] op_ff, op_in;

   // Clearing pass after reset, then sequencing of one beat through the tree
   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      op_in     = op_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            if (sts.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = req_op;
               res_in   = ST_OK;
               case (req_op)
                  OP_ALLOC: begin
                     state_in = S_CHECK;
                  end
                  OP_FREE, OP_QUERY: begin
                     if (sts.off_bad) begin
                        res_in   = ST_NOT_ALLOC;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_CLIMB;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (!sts.fits) begin
               res_in   = ST_NO_SPACE;
               state_in = S_DONE;
            end else if (sts.want_root) begin
               cmd.mark_root = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.probe = 1'b1;
               state_in  = S_DESC;
            end
         end
         S_DESC: begin
            cmd.desc = 1'b1;
            if (sts.desc_last) begin
               state_in = S_UP;
            end
         end
         S_CLIMB: begin
            if (sts.rd_zero) begin
               cmd.found = 1'b1;
               if (op_ff == OP_FREE) begin
                  cmd.restore = 1'b1;
                  state_in    = sts.idx_zero ? S_DONE : S_UP;
               end else begin
                  state_in = S_DONE;
               end
            end else if (sts.idx_zero) begin
               res_in   = ST_NOT_ALLOC;
               state_in = S_DONE;
            end else begin
               cmd.climb = 1'b1;
            end
         end
         S_UP: begin
            cmd.up = 1'b1;
            if (sts.up_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.status = res_ff;
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         res_ff   <= ST_OK;
         op_ff    <= '0;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
         op_ff    <= op_in;
      end
   end

endmodule

FILE: hdl/buddy_allocator_tree.sv
// Channel  Dir  Handshake            Beat
// req      in   req_valid/req_ready  req_type: op, request_units, block_offset
// rsp      out  rsp_valid/rsp_ready  rsp_type: status, granted_offset, block_units
//
// One beat at a time; one tree level per cycle through the node RAM
// (one write and one registered read each cycle).
// After reset a clearing pass writes all 2*POOL_UNITS-1 nodes, one per cycle,
// with req_ready low. A result waiting in the output register does not block
// the next request; it stalls only the final write of the following result.
module buddy_allocator_tree
   import bat_pkg::*;
#(
   parameter int POOL_UNITS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   bat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bat_dp #(
      .POOL_UNITS (POOL_UNITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A new result only appears after the controller finishes a beat
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result appeared without finish");

   // Never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("finish while output stalled");

   // At most one tree action per cycle
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.init, cmd.load, cmd.probe, cmd.desc, cmd.mark_root,
                cmd.climb, cmd.up, cmd.finish}))
      else $error("conflicting datapath actions");

   // A beat never completes in the cycle it is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after accept");

endmodule

FILE: tb/buddy_tree_checker.sv
`timescale 1ns / 1ps

module buddy_tree_checker
   import bat_pkg::*;
#(
   parameter int POOL_UNITS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      failures,
   output int      pending
);

   localparam int LEVELS = $clog2(POOL_UNITS);
   localparam int NODES  = 2 * POOL_UNITS - 1;

   // Largest free power-of-two block under each node; 0 = node taken whole
   logic [UNITS_W-1:0] largest_free [NODES];
   rsp_type            expected_rsp [$];

   task automatic report_mismatch(input string what);
      $display("%0t ns checker: %s", $time, what);
      failures++;
   endtask

   function automatic int ceil_pow2(input logic [UNITS_W-1:0] units);
      int p;
      p = 1;
      while (p < int'(units)) begin
         p = p * 2;
      end
      return p;
   endfunction

   function automatic void reset_tree();
      for (int lvl = 0; lvl <= LEVELS; lvl++) begin
         for (int k = 0; k < (1 << lvl); k++) begin
            largest_free[(1 << lvl) - 1 + k] = UNITS_W'(POOL_UNITS >> lvl);
         end
      end
   endfunction

   // Apply one request to the tree copy and return the beat it should produce
   function automatic rsp_type predict_buddy_op(input req_type beat);
      rsp_type res;
      int      want;
      int      node;
      int      span;
      int      lval;
      int      rval;
      bit      located;
      res.status         = ST_OK;
      res.granted_offset = '0;
      res.block_units    = '0;
      case (beat.op)
         OP_ALLOC: begin
            want = ceil_pow2(beat.request_units);
            if (want > POOL_UNITS || int'(largest_free[0]) < want) begin
               res.status = ST_NO_SPACE;
            end else begin
               // leftmost-first descent to the level of the rounded size
               node = 0;
               for (span = POOL_UNITS; span != want; span = span / 2) begin
                  node = (int'(largest_free[2*node+1]) >= want) ? 2*node+1 : 2*node+2;
               end
               largest_free[node] = '0;
               res.granted_offset = OFFSET_W'((node + 1) * span - POOL_UNITS);
               res.block_units    = UNITS_W'(want);
               while (node != 0) begin
                  node = (node - 1) / 2;
                  lval = largest_free[2*node+1];
                  rval = largest_free[2*node+2];
                  largest_free[node] = UNITS_W'((lval > rval) ? lval : rval);
               end
            end
         end
         OP_FREE, OP_QUERY: begin
            // climb from the leaf to the first taken node
            located = 1'b0;
            if (int'(beat.block_offset) < POOL_UNITS) begin
               node    = int'(beat.block_offset) + POOL_UNITS - 1;
               span    = 1;
               located = 1'b1;
               while (largest_free[node] != '0) begin
                  if (node == 0) begin
                     located = 1'b0;
                     break;
                  end
                  node = (node - 1) / 2;
                  span = span * 2;
               end
            end
            if (!located) begin
               res.status = ST_NOT_ALLOC;
            end else begin
               res.block_units = UNITS_W'(span);
               if (beat.op == OP_FREE) begin
                  // restore and merge buddies on the way up
                  largest_free[node] = UNITS_W'(span);
                  while (node != 0) begin
                     node = (node - 1) / 2;
                     span = span * 2;
                     lval = largest_free[2*node+1];
                     rval = largest_free[2*node+2];
                     if (lval + rval == span) begin
                        largest_free[node] = UNITS_W'(span);
                     end else begin
                        largest_free[node] = UNITS_W'((lval > rval) ? lval : rval);
                     end
                  end
               end
            end
         end
         default: begin
            // undefined op: all-zero beat, tree untouched
         end
      endcase
      return res;
   endfunction

   // Sample both channels; compare results before queueing the new request
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         reset_tree();
         expected_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing pending: %h", rsp_data));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.granted_offset !== want.granted_offset)
                  report_mismatch($sformatf("granted_offset %0d, want %0d",
                                            rsp_data.granted_offset, want.granted_offset));
               if (rsp_data.block_units !== want.block_units)
                  report_mismatch($sformatf("block_units %0d, want %0d",
                                            rsp_data.block_units, want.block_units));
            end
         end
         if (req_valid && req_ready) begin
            expected_rsp.push_back(predict_buddy_op(req_data));
         end
      end
      pending = expected_rsp.size();
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import bat_pkg::*;

   localparam int POOL_UNITS   = 256;
   localparam int RANDOM_BEATS = 1300;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

   typedef struct {
      logic [OFFSET_W-1:0] base;
      logic [UNITS_W-1:0]  units;
   } held_block;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      cycle_count = 0;

   // Blocks granted so far, used to build well-formed frees and queries
   held_block         held_blocks [$];
   logic [OP_W-1:0]   ops_in_flight [$];
   int                send_calm = 0;
   int                ready_hold = 0;
   int                ready_calm = 0;

   buddy_allocator_tree #(
      .POOL_UNITS(POOL_UNITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   buddy_tree_checker #(
      .POOL_UNITS(POOL_UNITS)
   ) checker_inst (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Result side stalls, with occasional stretches of steady ready
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else if (ready_calm > 0) begin
         ready_calm <= ready_calm - 1;
         rsp_ready  <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 199) == 0) begin
            ready_calm <= $urandom_range(50, 300);
         end else begin
            ready_hold <= pick_gap();
         end
      end
   end

   // Track granted blocks from the result beats
   always @(posedge clock) begin
      logic [OP_W-1:0] op;
      held_block       blk;
      if (!reset) begin
         if (rsp_valid && rsp_ready && ops_in_flight.size() > 0) begin
            op = ops_in_flight.pop_front();
            if (op == OP_ALLOC && rsp_data.status == ST_OK) begin
               blk.base  = rsp_data.granted_offset;
               blk.units = rsp_data.block_units;
               held_blocks.push_back(blk);
            end
         end
         if (req_valid && req_ready) begin
            ops_in_flight.push_back(req_data.op);
         end
      end
   end

   // Drive one beat from a falling edge, hold it until accepted, then maybe idle
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [UNITS_W-1:0] units,
                            input logic [OFFSET_W-1:0] offset);
      int gap;
      req_data.op            <= op;
      req_data.request_units <= units;
      req_data.block_offset  <= offset;
      req_valid              <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (send_calm > 0) begin
         send_calm--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 149) == 0) send_calm = $urandom_range(30, 120);
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Hold off the sender until every pending result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   // Mostly allocs of small sizes and frees of live blocks, plus noise
   task automatic send_random_beat();
      int                  r;
      int                  pick;
      logic [UNITS_W-1:0]  units;
      logic [OFFSET_W-1:0] offset;
      r      = $urandom_range(0, 99);
      units  = UNITS_W'($urandom);
      offset = OFFSET_W'($urandom);
      if (r < 45 && held_blocks.size() > 24) r = 60;
      if (r < 45) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)      units = UNITS_W'($urandom_range(0, 8));
         else if (pick < 90) units = UNITS_W'($urandom_range(9, 64));
         else if (pick < 98) units = UNITS_W'($urandom_range(65, 256));
         else                units = UNITS_W'($urandom_range(257, 511));
         send_beat(OP_ALLOC, units, offset);
      end else if (r < 88 && held_blocks.size() > 0) begin
         pick   = $urandom_range(0, held_blocks.size() - 1);
         offset = OFFSET_W'(held_blocks[pick].base +
                            $urandom_range(0, held_blocks[pick].units - 1));
         if (r < 80) begin
            held_blocks.delete(pick);
            send_beat(OP_FREE, units, offset);
         end else begin
            send_beat(OP_QUERY, units, offset);
         end
      end else if (r < 97) begin
         send_beat(($urandom_range(0, 1) == 0) ? OP_FREE : OP_QUERY, units, offset);
      end else begin
         send_beat(OP_UNDEFINED, units, offset);
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // whole pool, access inside it, exhaustion and never-allocated offsets
      send_beat(OP_ALLOC, 9'd256, 8'd0);
      send_beat(OP_QUERY, 9'd0, 8'd0);
      send_beat(OP_ALLOC, 9'd1, 8'd0);
      send_beat(OP_FREE, 9'd0, 8'd255);
      send_beat(OP_FREE, 9'd0, 8'd0);
      send_beat(OP_QUERY, 9'd511, 8'd255);
      // zero rounds to one, odd sizes round up
      send_beat(OP_ALLOC, 9'd0, 8'd0);
      send_beat(OP_ALLOC, 9'd1, 8'd0);
      send_beat(OP_ALLOC, 9'd3, 8'd0);
      send_beat(OP_ALLOC, 9'd2, 8'd0);
      send_beat(OP_ALLOC, 9'd128, 8'd0);
      send_beat(OP_ALLOC, 9'd257, 8'd0);
      send_beat(OP_ALLOC, 9'd511, 8'd255);
      send_beat(OP_ALLOC, 9'd64, 8'd0);
      send_beat(OP_ALLOC, 9'd32, 8'd0);
      send_beat(OP_QUERY, 9'd0, 8'd7);
      send_beat(OP_FREE, 9'd0, 8'd6);
      send_beat(OP_UNDEFINED, 9'd511, 8'd255);
      send_beat(OP_UNDEFINED, 9'd0, 8'd0);
      // free the rest, buddies merge back to the full pool
      send_beat(OP_FREE, 9'd0, 8'd1);
      send_beat(OP_FREE, 9'd0, 8'd0);
      send_beat(OP_FREE, 9'd0, 8'd2);
      send_beat(OP_FREE, 9'd0, 8'd200);
      send_beat(OP_FREE, 9'd0, 8'd64);
      send_beat(OP_FREE, 9'd0, 8'd40);
      drain_results();
      held_blocks.delete();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         send_random_beat();
         if ($urandom_range(0, 199) == 0) drain_results();
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (failures == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
